FILE: hdl/serial_eeprom_loader_top_defines.svh
// Assertion macros for the serial EEPROM loader sequencer.
`ifndef SERIAL_EEPROM_LOADER_TOP_DEFINES_SVH
`define SERIAL_EEPROM_LOADER_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SEL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("serial eeprom loader: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define SEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("serial eeprom loader: next-cycle check failed");

`endif

FILE: hdl/sel_pkg.sv
// Shared constants and types of the serial EEPROM loader.
package sel_pkg;

    // Command framing and data word
    localparam int CMD_BITS    = 3;
    localparam int READ_OPCODE = 6;
    localparam int DATA_BITS   = 16;

    localparam int WORD_W    = 16;
    localparam int ADDR_W    = 7;
    localparam int SEQ_W     = 16;
    localparam int BIT_CNT_W = 5;
    localparam int PHASE_W   = 3;
    localparam int STATUS_W  = 2;

    localparam logic [WORD_W-1:0] DATA_MASK = WORD_W'((1 << DATA_BITS) - 1);

    // Part geometry
    localparam int ABITS_SMALL = 6;
    localparam int ABITS_LARGE = 8;
    localparam int WORDS_SMALL = 64;
    localparam int WORDS_LARGE = 128;
    localparam logic [ADDR_W-1:0] LAST_SMALL = ADDR_W'(WORDS_SMALL - 1);
    localparam logic [ADDR_W-1:0] LAST_LARGE = ADDR_W'(WORDS_LARGE - 1);
    localparam logic [7:0] MIN_VER_SMALL = 8'd2;
    localparam logic [7:0] MIN_VER_LARGE = 8'd1;

    // Header words and checks
    localparam logic [ADDR_W-1:0] ADDR_ID0   = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_ID1   = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_VER   = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] ADDR_CHECK = ADDR_W'(4);
    localparam logic [7:0] CHR_I     = 8'h49;
    localparam logic [7:0] CHR_S     = 8'h53;
    localparam logic [7:0] CHR_P     = 8'h50;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // Sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRECLK = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SHOUT  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SHIN   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DESEL  = 3'd4;

    // Sub-phase codes within one bit
    localparam logic [1:0] SUB_0 = 2'd0;
    localparam logic [1:0] SUB_1 = 2'd1;
    localparam logic [1:0] SUB_2 = 2'd2;

    // Load status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HDR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM = 2'd2;

    // One result word
    typedef struct packed {
        logic                chip_select;
        logic                serial_clock;
        logic                serial_data_out;
        logic                word_valid;
        logic [ADDR_W-1:0]   word_index;
        logic [WORD_W-1:0]   word_value;
        logic                busy_res;
        logic                finished;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

FILE: hdl/sel_engine.sv
// Load sequencer: state registers and single-pass next-state and pin logic.
`include "serial_eeprom_loader_top_defines.svh"

module sel_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_cmd,
    input  logic             i_din,
    input  logic             i_small_part,
    output sel_pkg::t_result o_res
);

    logic [sel_pkg::PHASE_W-1:0]   r_phase, n_phase;
    logic [sel_pkg::BIT_CNT_W-1:0] r_bit_counter, n_bit_counter;
    logic [1:0]                    r_sub_phase, n_sub_phase;
    logic [sel_pkg::ADDR_W-1:0]    r_word_address, n_word_address;
    logic [sel_pkg::WORD_W-1:0]    r_shift, n_shift;
    logic [7:0]                    r_byte_sum, n_byte_sum;
    logic                          r_header_match, n_header_match;
    logic [sel_pkg::STATUS_W-1:0]  r_last_status, n_last_status;

    logic [sel_pkg::SEQ_W-1:0]     seq;
    logic [sel_pkg::BIT_CNT_W-1:0] start_cnt;
    logic [sel_pkg::WORD_W-1:0]    w;
    logic [7:0]                    lo, hi, sum, min_ver;
    logic                          hdr_ok, last_word;

    // Build the command sequence and per-part limits
    always_comb begin
        if (i_small_part) begin
            seq = (sel_pkg::SEQ_W'(sel_pkg::READ_OPCODE) << sel_pkg::ABITS_SMALL)
                | sel_pkg::SEQ_W'(r_word_address);
            start_cnt = sel_pkg::BIT_CNT_W'(sel_pkg::CMD_BITS + sel_pkg::ABITS_SMALL - 1);
            min_ver   = sel_pkg::MIN_VER_SMALL;
            last_word = (r_word_address >= sel_pkg::LAST_SMALL);
        end else begin
            seq = (sel_pkg::SEQ_W'(sel_pkg::READ_OPCODE) << sel_pkg::ABITS_LARGE)
                | sel_pkg::SEQ_W'(r_word_address);
            start_cnt = sel_pkg::BIT_CNT_W'(sel_pkg::CMD_BITS + sel_pkg::ABITS_LARGE - 1);
            min_ver   = sel_pkg::MIN_VER_LARGE;
            last_word = (r_word_address >= sel_pkg::LAST_LARGE);
        end
    end

    // Split the finished word into bytes and update the header check
    always_comb begin
        w   = r_shift & sel_pkg::DATA_MASK;
        lo  = w[7:0];
        hi  = w[15:8];
        sum = r_byte_sum + lo + hi;
        hdr_ok = r_header_match;
        if (r_word_address == sel_pkg::ADDR_ID0 && (lo != sel_pkg::CHR_I || hi != sel_pkg::CHR_S))
            hdr_ok = 1'b0;
        if (r_word_address == sel_pkg::ADDR_ID1
            && (lo != sel_pkg::CHR_P || hi != sel_pkg::CHR_SPACE))
            hdr_ok = 1'b0;
        if (r_word_address == sel_pkg::ADDR_VER && lo < min_ver)
            hdr_ok = 1'b0;
    end

    // Advance the sequencer by one pin access
    always_comb begin
        n_phase        = r_phase;
        n_bit_counter  = r_bit_counter;
        n_sub_phase    = r_sub_phase;
        n_word_address = r_word_address;
        n_shift        = r_shift;
        n_byte_sum     = r_byte_sum;
        n_header_match = r_header_match;
        n_last_status  = r_last_status;
        o_res          = '0;

        if (i_cmd) begin
            n_word_address    = '0;
            n_byte_sum        = '0;
            n_header_match    = 1'b1;
            n_shift           = '0;
            n_bit_counter     = '0;
            n_sub_phase       = sel_pkg::SUB_0;
            n_phase           = sel_pkg::PH_PRECLK;
            o_res.chip_select = 1'b1;
        end else begin
            case (r_phase)
                sel_pkg::PH_PRECLK: begin
                    o_res.chip_select  = 1'b1;
                    o_res.serial_clock = 1'b1;
                    n_phase       = sel_pkg::PH_SHOUT;
                    n_sub_phase   = sel_pkg::SUB_0;
                    n_bit_counter = start_cnt;
                end
                sel_pkg::PH_SHOUT: begin
                    o_res.chip_select     = 1'b1;
                    o_res.serial_data_out = seq[r_bit_counter[3:0]];
                    o_res.serial_clock    = (r_sub_phase == sel_pkg::SUB_1);
                    if (r_sub_phase >= sel_pkg::SUB_2) begin
                        n_sub_phase = sel_pkg::SUB_0;
                        if (r_bit_counter == '0) begin
                            n_phase = sel_pkg::PH_SHIN;
                            n_shift = '0;
                        end else begin
                            n_bit_counter = r_bit_counter - 1'b1;
                        end
                    end else begin
                        n_sub_phase = r_sub_phase + 1'b1;
                    end
                end
                sel_pkg::PH_SHIN: begin
                    o_res.chip_select = 1'b1;
                    if (r_sub_phase == sel_pkg::SUB_0) begin
                        o_res.serial_clock = 1'b1;
                        n_sub_phase = sel_pkg::SUB_1;
                    end else if (r_sub_phase == sel_pkg::SUB_1) begin
                        o_res.serial_clock = 1'b1;
                        n_shift     = {r_shift[sel_pkg::WORD_W-2:0], i_din};
                        n_sub_phase = sel_pkg::SUB_2;
                    end else begin
                        n_sub_phase = sel_pkg::SUB_0;
                        if (r_bit_counter >= sel_pkg::BIT_CNT_W'(sel_pkg::DATA_BITS - 1))
                            n_phase = sel_pkg::PH_DESEL;
                        else
                            n_bit_counter = r_bit_counter + 1'b1;
                    end
                end
                sel_pkg::PH_DESEL: begin
                    o_res.word_valid = 1'b1;
                    o_res.word_index = r_word_address;
                    o_res.word_value = w;
                    n_byte_sum       = sum;
                    n_header_match   = hdr_ok;
                    if (r_word_address == sel_pkg::ADDR_CHECK && !hdr_ok) begin
                        n_last_status  = sel_pkg::ST_BAD_HDR;
                        o_res.finished = 1'b1;
                        n_phase        = sel_pkg::PH_IDLE;
                    end else if (last_word) begin
                        n_last_status  = (sum == 8'd0) ? sel_pkg::ST_OK : sel_pkg::ST_BAD_SUM;
                        o_res.finished = 1'b1;
                        n_phase        = sel_pkg::PH_IDLE;
                    end else begin
                        n_word_address = r_word_address + 1'b1;
                        n_phase        = sel_pkg::PH_SHOUT;
                        n_sub_phase    = sel_pkg::SUB_0;
                        n_bit_counter  = start_cnt;
                    end
                end
                default: begin
                    n_phase = sel_pkg::PH_IDLE;
                end
            endcase
        end

        o_res.busy_res = (n_phase != sel_pkg::PH_IDLE);
        o_res.status   = n_last_status;
    end

    // Hold state unless a word advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= sel_pkg::PH_IDLE;
            r_bit_counter  <= '0;
            r_sub_phase    <= sel_pkg::SUB_0;
            r_word_address <= '0;
            r_shift        <= '0;
            r_byte_sum     <= '0;
            r_header_match <= 1'b1;
            r_last_status  <= sel_pkg::ST_OK;
        end else if (i_adv) begin
            r_phase        <= n_phase;
            r_bit_counter  <= n_bit_counter;
            r_sub_phase    <= n_sub_phase;
            r_word_address <= n_word_address;
            r_shift        <= n_shift;
            r_byte_sum     <= n_byte_sum;
            r_header_match <= n_header_match;
            r_last_status  <= n_last_status;
        end
    end

    `SEL_ASSERT_NEXT(a_start_preclk, i_clk, i_rst_n, i_adv && i_cmd, r_phase == sel_pkg::PH_PRECLK)
    `SEL_ASSERT_NEXT(a_finish_idle, i_clk, i_rst_n, i_adv && o_res.finished, r_phase == sel_pkg::PH_IDLE)
    `SEL_ASSERT_NEXT(a_hold_state, i_clk, i_rst_n, !i_adv, $stable(r_phase) && $stable(r_shift))
    `SEL_ASSERT_SAME(a_word_in_desel, i_clk, i_rst_n, o_res.word_valid, r_phase == sel_pkg::PH_DESEL && !i_cmd)

endmodule

FILE: hdl/serial_eeprom_loader_top.sv
// Top level of the serial EEPROM loader: input register, sequencer, result register.
// Each input word is one pin-access tick (or a start command) and the block takes one
// word every clock cycle when the result side is not stalling. A word waits in the input
// register, where the sequencer's single-pass next-state and pin logic evaluates it, and
// moves into the result register once that register is free or draining. The result
// register parts the two sides: a new word can enter the input register while a finished
// result still waits to be taken. The part-size register is always ready; the user must
// write it only while no load work is in flight, as the block itself does not enforce this.
module serial_eeprom_loader_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_cmd,
    input  logic                           i_serial_data_in,
    // Configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_small_part,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_chip_select,
    output logic                           o_serial_clock,
    output logic                           o_serial_data_out,
    output logic                           o_word_valid,
    output logic [sel_pkg::ADDR_W-1:0]     o_word_index,
    output logic [sel_pkg::WORD_W-1:0]     o_word_value,
    output logic                           o_busy_res,
    output logic                           o_finished,
    output logic [sel_pkg::STATUS_W-1:0]   o_status
);

    logic             r_small_part;
    logic             r_in_valid;
    logic             r_cmd;
    logic             r_din;
    logic             r_out_valid;
    sel_pkg::t_result r_out;
    sel_pkg::t_result res;
    logic             out_load;
    logic             in_load;

    // Move a word forward when the slot ahead is free or draining
    assign out_load    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_load     = !r_in_valid || out_load;
    assign o_in_stall  = !in_load;
    assign o_cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_part <= 1'b0;
        end else if (i_cfg_valid) begin
            r_small_part <= i_cfg_small_part;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_cmd <= i_cmd;
            r_din <= i_serial_data_in;
        end
    end

    sel_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (out_load),
        .i_cmd        (r_cmd),
        .i_din        (r_din),
        .i_small_part (r_small_part),
        .o_res        (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_chip_select     = r_out.chip_select;
    assign o_serial_clock    = r_out.serial_clock;
    assign o_serial_data_out = r_out.serial_data_out;
    assign o_word_valid      = r_out.word_valid;
    assign o_word_index      = r_out.word_index;
    assign o_word_value      = r_out.word_value;
    assign o_busy_res        = r_out.busy_res;
    assign o_finished        = r_out.finished;
    assign o_status          = r_out.status;

endmodule

FILE: dv/serial_eeprom_loader_top_test.sv
// Self-checking testbench for the serial EEPROM loader: pin sequence, word reports, status.
module serial_eeprom_loader_top_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 120;
    localparam int RANDOM_TICKS = 750;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_cmd = 1'b0;
    logic                           i_serial_data_in = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic                           i_cfg_small_part = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic                           o_chip_select;
    logic                           o_serial_clock;
    logic                           o_serial_data_out;
    logic                           o_word_valid;
    logic [sel_pkg::ADDR_W-1:0]     o_word_index;
    logic [sel_pkg::WORD_W-1:0]     o_word_value;
    logic                           o_busy_res;
    logic                           o_finished;
    logic [sel_pkg::STATUS_W-1:0]   o_status;

    serial_eeprom_loader_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_serial_data_in  (i_serial_data_in),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_small_part  (i_cfg_small_part),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_chip_select     (o_chip_select),
        .o_serial_clock    (o_serial_clock),
        .o_serial_data_out (o_serial_data_out),
        .o_word_valid      (o_word_valid),
        .o_word_index      (o_word_index),
        .o_word_value      (o_word_value),
        .o_busy_res        (o_busy_res),
        .o_finished        (o_finished),
        .o_status          (o_status)
    );

    // Loader state as the testbench tracks it
    logic                           part_small = 1'b0;
    logic [sel_pkg::PHASE_W-1:0]    seq_phase = sel_pkg::PH_IDLE;
    logic [sel_pkg::BIT_CNT_W-1:0]  bit_cnt = '0;
    logic [1:0]                     sub_cnt = sel_pkg::SUB_0;
    logic [sel_pkg::ADDR_W-1:0]     waddr = '0;
    logic [sel_pkg::WORD_W-1:0]     shreg = '0;
    logic [7:0]                     sum8 = '0;
    logic                           hdr_ok = 1'b1;
    logic [sel_pkg::STATUS_W-1:0]   load_status = sel_pkg::ST_OK;

    sel_pkg::t_result               expected_pin_states[$];
    sel_pkg::t_result               want_pins;
    logic [sel_pkg::WORD_W-1:0]     eeprom_image [sel_pkg::WORDS_LARGE];

    int  mismatch_count = 0;
    int  results_checked = 0;
    int  tick_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_request = 1'b0;
    bit  no_idle = 1'b0;

    always #10 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the result side at random unless idling is off, or hold it off for a long stretch on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (no_idle) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 22);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each accepted result word with the oldest expectation
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pin_states.size() == 0) begin
                $error("result word arrived with no pending tick");
                mismatch_count++;
            end else begin
                want_pins = expected_pin_states.pop_front();
                check_field("chip_select", want_pins.chip_select, o_chip_select);
                check_field("serial_clock", want_pins.serial_clock, o_serial_clock);
                check_field("serial_data_out", want_pins.serial_data_out, o_serial_data_out);
                check_field("word_valid", want_pins.word_valid, o_word_valid);
                check_field("word_index", want_pins.word_index, o_word_index);
                check_field("word_value", want_pins.word_value, o_word_value);
                check_field("busy_res", want_pins.busy_res, o_busy_res);
                check_field("finished", want_pins.finished, o_finished);
                check_field("status", want_pins.status, o_status);
                results_checked++;
            end
        end
    end

    // Load the command and address bit counter for the current word
    task automatic begin_address_shift();
        seq_phase = sel_pkg::PH_SHOUT;
        sub_cnt = sel_pkg::SUB_0;
        bit_cnt = sel_pkg::BIT_CNT_W'(sel_pkg::CMD_BITS
            + (part_small ? sel_pkg::ABITS_SMALL : sel_pkg::ABITS_LARGE) - 1);
    endtask

    // Advance the tracked loader by one tick and queue the pins it should show
    task automatic predict_tick(input logic cmd, input logic din);
        sel_pkg::t_result r;
        int unsigned abits, seq, min_ver, words;
        logic [sel_pkg::WORD_W-1:0] w;
        r = '0;
        abits = part_small ? sel_pkg::ABITS_SMALL : sel_pkg::ABITS_LARGE;
        words = part_small ? sel_pkg::WORDS_SMALL : sel_pkg::WORDS_LARGE;
        min_ver = part_small ? sel_pkg::MIN_VER_SMALL : sel_pkg::MIN_VER_LARGE;
        if (cmd) begin
            waddr = '0;
            sum8 = '0;
            hdr_ok = 1'b1;
            shreg = '0;
            bit_cnt = '0;
            sub_cnt = sel_pkg::SUB_0;
            seq_phase = sel_pkg::PH_PRECLK;
            r.chip_select = 1'b1;
        end else begin
            case (seq_phase)
                sel_pkg::PH_PRECLK: begin
                    r.chip_select = 1'b1;
                    r.serial_clock = 1'b1;
                    begin_address_shift();
                end
                sel_pkg::PH_SHOUT: begin
                    seq = (sel_pkg::READ_OPCODE << abits) | waddr;
                    r.chip_select = 1'b1;
                    r.serial_data_out = 1'((seq >> bit_cnt) & 1);
                    r.serial_clock = (sub_cnt == sel_pkg::SUB_1);
                    if (sub_cnt >= sel_pkg::SUB_2) begin
                        sub_cnt = sel_pkg::SUB_0;
                        if (bit_cnt == 0) begin
                            seq_phase = sel_pkg::PH_SHIN;
                            shreg = '0;
                        end else begin
                            bit_cnt--;
                        end
                    end else begin
                        sub_cnt++;
                    end
                end
                sel_pkg::PH_SHIN: begin
                    r.chip_select = 1'b1;
                    if (sub_cnt == sel_pkg::SUB_0) begin
                        r.serial_clock = 1'b1;
                        sub_cnt = sel_pkg::SUB_1;
                    end else if (sub_cnt == sel_pkg::SUB_1) begin
                        r.serial_clock = 1'b1;
                        shreg = {shreg[sel_pkg::WORD_W-2:0], din};
                        sub_cnt = sel_pkg::SUB_2;
                    end else begin
                        sub_cnt = sel_pkg::SUB_0;
                        if (bit_cnt >= sel_pkg::DATA_BITS - 1)
                            seq_phase = sel_pkg::PH_DESEL;
                        else
                            bit_cnt++;
                    end
                end
                sel_pkg::PH_DESEL: begin
                    w = shreg & sel_pkg::DATA_MASK;
                    r.word_valid = 1'b1;
                    r.word_index = waddr;
                    r.word_value = w;
                    sum8 = sum8 + w[7:0] + w[15:8];
                    if (waddr == sel_pkg::ADDR_ID0
                        && (w[7:0] != sel_pkg::CHR_I || w[15:8] != sel_pkg::CHR_S))
                        hdr_ok = 1'b0;
                    if (waddr == sel_pkg::ADDR_ID1
                        && (w[7:0] != sel_pkg::CHR_P || w[15:8] != sel_pkg::CHR_SPACE))
                        hdr_ok = 1'b0;
                    if (waddr == sel_pkg::ADDR_VER && w[7:0] < min_ver)
                        hdr_ok = 1'b0;
                    if (waddr == sel_pkg::ADDR_CHECK && !hdr_ok) begin
                        load_status = sel_pkg::ST_BAD_HDR;
                        r.finished = 1'b1;
                        seq_phase = sel_pkg::PH_IDLE;
                    end else if (waddr + 1 >= words) begin
                        load_status = (sum8 == 0) ? sel_pkg::ST_OK : sel_pkg::ST_BAD_SUM;
                        r.finished = 1'b1;
                        seq_phase = sel_pkg::PH_IDLE;
                    end else begin
                        waddr++;
                        begin_address_shift();
                    end
                end
                default: begin
                    seq_phase = sel_pkg::PH_IDLE;
                end
            endcase
        end
        r.busy_res = (seq_phase != sel_pkg::PH_IDLE);
        r.status = load_status;
        expected_pin_states.push_back(r);
    endtask

    // Offer one tick word, hold it until accepted, then predict its pins
    task automatic send_tick(input logic cmd, input logic din);
        int gap;
        logic stalled;
        gap = 0;
        while (!no_idle && $urandom_range(99) < 22)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_serial_data_in <= din;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        if (cmd || seq_phase != sel_pkg::PH_IDLE)
            tick_count++;
        predict_tick(cmd, din);
    endtask

    // Drive the image bit on a read tick, noise on any other tick
    function automatic logic image_bit();
        if (seq_phase == sel_pkg::PH_SHIN && sub_cnt == sel_pkg::SUB_1)
            return eeprom_image[waddr][sel_pkg::DATA_BITS - 1 - bit_cnt];
        return 1'($urandom_range(1));
    endfunction

    // Drop valid and wait until every queued result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_pin_states.size() != 0);
    endtask

    // Tick with random data until the load ends
    task automatic finish_load();
        while (seq_phase != sel_pkg::PH_IDLE)
            send_tick(1'b0, 1'($urandom_range(1)));
    endtask

    // Write the part-size register with the loader and pipeline idle
    task automatic set_part_size(input logic small_sel);
        logic ready_seen;
        finish_load();
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_small_part <= small_sel;
        do begin
            @(negedge i_clk);
            ready_seen = o_cfg_ready;
            @(posedge i_clk);
        end while (!ready_seen);
        i_cfg_valid <= 1'b0;
        part_small = small_sel;
    endtask

    // Fill the EEPROM image: header, version, and a last byte that sets the checksum
    task automatic build_image(input bit corrupt_id, input logic [7:0] version, input bit sum_ok);
        int words, pick;
        logic [7:0] total;
        words = part_small ? sel_pkg::WORDS_SMALL : sel_pkg::WORDS_LARGE;
        foreach (eeprom_image[i])
            eeprom_image[i] = sel_pkg::WORD_W'($urandom);
        eeprom_image[sel_pkg::ADDR_ID0] = {sel_pkg::CHR_S, sel_pkg::CHR_I};
        eeprom_image[sel_pkg::ADDR_ID1] = {sel_pkg::CHR_SPACE, sel_pkg::CHR_P};
        eeprom_image[sel_pkg::ADDR_VER][7:0] = version;
        if (corrupt_id) begin
            pick = $urandom_range(3);
            eeprom_image[pick / 2] ^= sel_pkg::WORD_W'(1)
                << ($urandom_range(7) + 8 * (pick % 2));
        end
        eeprom_image[words - 1][7:0] = 8'd0;
        total = 8'd0;
        for (int i = 0; i < words; i++)
            total = total + eeprom_image[i][7:0] + eeprom_image[i][15:8];
        eeprom_image[words - 1][7:0] = (8'd0 - total)
            + (sum_ok ? 8'd0 : 8'($urandom_range(255, 1)));
    endtask

    // Start a load and feed the image; optionally restart on a read tick
    task automatic run_load(input int restart_after);
        int n;
        bit restarted;
        n = 0;
        restarted = 1'b0;
        send_tick(1'b1, 1'($urandom_range(1)));
        while (seq_phase != sel_pkg::PH_IDLE) begin
            n++;
            if (restart_after > 0 && !restarted && n >= restart_after
                && seq_phase == sel_pkg::PH_SHIN && sub_cnt == sel_pkg::SUB_1) begin
                restarted = 1'b1;
                send_tick(1'b1, 1'($urandom_range(1)));
            end else begin
                send_tick(1'b0, image_bit());
            end
        end
    endtask

    // Idle ticks, start, restart while busy, then let the header check stop it
    task automatic test_directed();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        repeat (19) send_tick(1'b0, 1'($urandom_range(1)));
        finish_load();
    endtask

    // Full 64-word load at the minimum version with a good checksum, no idling
    task automatic test_small_full_load();
        set_part_size(1'b1);
        no_idle = 1'b1;
        build_image(1'b0, sel_pkg::MIN_VER_SMALL, 1'b1);
        run_load(0);
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Full 128-word load with a bad checksum, result side held off at the start
    task automatic test_large_full_load();
        set_part_size(1'b0);
        build_image(1'b0, sel_pkg::MIN_VER_LARGE, 1'b0);
        hold_request = 1'b1;
        run_load(0);
    endtask

    // Bad ID, version below minimum and restart mid-load, for both part sizes
    task automatic test_header_failures();
        logic [7:0] min_ver;
        for (int s = 1; s >= 0; s--) begin
            set_part_size(1'(s));
            min_ver = s ? sel_pkg::MIN_VER_SMALL : sel_pkg::MIN_VER_LARGE;
            build_image(1'b1, 8'hFF, 1'b1);
            run_load(0);
            build_image(1'b0, min_ver - 8'd1, 1'b1);
            run_load(0);
            build_image(1'b1, min_ver, 1'b1);
            run_load($urandom_range(300, 30));
        end
    endtask

    // Mostly loads that fail the header with random content, some random tick bursts
    task automatic test_random_ticks();
        int first;
        bit corrupt;
        set_part_size(1'($urandom_range(1)));
        first = tick_count;
        while (tick_count - first < RANDOM_TICKS) begin
            if ($urandom_range(99) < 70) begin
                corrupt = ($urandom_range(99) < 60);
                build_image(corrupt,
                            corrupt ? 8'($urandom) : 8'($urandom_range(part_small)), 1'b1);
                run_load(($urandom_range(3) == 0) ? $urandom_range(200, 5) : 0);
            end else begin
                repeat ($urandom_range(40, 1))
                    send_tick(1'($urandom_range(19) == 0), 1'($urandom_range(1)));
            end
        end
        finish_load();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_small_full_load();
        test_large_full_load();
        test_header_failures();
        test_random_ticks();
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered both part sizes: full loads with good and bad checksum, ID and version");
        $display("rejects, restarts and random ticks; %0d ticks sent, %0d results checked",
                 tick_count, results_checked);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
